// ===== hw/rtl/mvna_pkg.sv =====
package mvna_pkg;

  localparam int NumVertices = 1024;
  localparam int AddrW = $clog2(NumVertices);
  localparam int IdxW = 10;
  localparam int PosW = 16;
  localparam int SumW = 48;
  localparam int CrossW = 38;
  localparam int NormW = 16;
  localparam int UnitOne = 16384;

  localparam logic [1:0] ReqWrite    = 2'd0;
  localparam logic [1:0] ReqTriangle = 2'd1;
  localparam logic [1:0] ReqRead     = 2'd2;
  localparam logic [1:0] ReqUnused   = 2'd3;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [1:0] {
    SelA,
    SelB,
    SelC,
    SelVertex
  } addr_sel_e;

  typedef enum logic [3:0] {
    MulUyWz,
    MulUzWy,
    MulUzWx,
    MulUxWz,
    MulUxWy,
    MulUyWx,
    MulSq0,
    MulSq1,
    MulSq2
  } mul_sel_e;

  typedef struct packed {
    logic [1:0]             req_type;
    idx_t                   vertex_index;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    idx_t                   corner_a;
    idx_t                   corner_b;
    idx_t                   corner_c;
  } req_item_t;

  typedef struct packed {
    idx_t                    normal_index;
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    zero_normal;
  } rsp_item_t;

  typedef struct packed {
    logic      load_req;
    logic      vert_wr;
    logic      clr_wr;
    logic      pos_rd;
    logic      sum_rd;
    addr_sel_e addr_sel;
    logic      cap_p0;
    logic      cap_pb;
    logic      cap_pc;
    logic      mul_en;
    mul_sel_e  mul_sel;
    logic      sum_wr;
    logic      load_mag;
    logic      norm_step;
    logic      sqrt_init;
    logic      sqrt_step;
    logic      div_init;
    logic      div_step;
    logic      div_store;
    logic [1:0] comp;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] req_type;
    logic       vert_ok;
    logic       tri_ok;
    logic       is_zero;
    logic       norm_done;
    logic       out_free;
  } sts_t;

  function automatic logic idx_in_range(idx_t idx);
    return 32'(idx) < NumVertices;
  endfunction

  function automatic addr_t to_addr(idx_t idx);
    return AddrW'(idx);
  endfunction

endpackage

// ===== hw/rtl/mvna_if.sv =====
interface mvna_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [9:0]        vertex_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [9:0]        corner_a;
  logic [9:0]        corner_b;
  logic [9:0]        corner_c;

  modport source (
    output valid, req_type, vertex_index, pos_x, pos_y, pos_z,
           corner_a, corner_b, corner_c,
    input  ready
  );
  modport sink (
    input  valid, req_type, vertex_index, pos_x, pos_y, pos_z,
           corner_a, corner_b, corner_c,
    output ready
  );
endinterface

interface mvna_rsp_if;
  logic              valid;
  logic              ready;
  logic [9:0]        normal_index;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic              zero_normal;

  modport source (
    output valid, normal_index, normal_x, normal_y, normal_z, zero_normal,
    input  ready
  );
  modport sink (
    input  valid, normal_index, normal_x, normal_y, normal_z, zero_normal,
    output ready
  );
endinterface

// ===== hw/rtl/mesh_vertex_normal_accumulator_core.sv =====
// Area-weighted vertex normal accumulator. After reset the block clears its
// 1024 normal sums, one per cycle, and takes no request until the clear is done.
// A triangle takes three position reads, six products on one shared multiplier
// and three read-modify-writes of the sums. A normal read of a nonzero sum
// makes up to 24 one-bit normalizing shifts, a bit-serial square root (26 steps)
// and three sequential 15-step divides; a zero sum skips them.
// Requests are taken one at a time; a finished result waits in an output
// register while the next request is processed.
module mesh_vertex_normal_accumulator_core (
  input logic        clk_i,
  input logic        rst_ni,
  mvna_req_if.sink   req_i,
  mvna_rsp_if.source rsp_o
);
  import mvna_pkg::*;

  cmd_t      cmd;
  sts_t      sts;
  req_item_t req_item;
  rsp_item_t rsp_item;

  assign req_item.req_type     = req_i.req_type;
  assign req_item.vertex_index = req_i.vertex_index;
  assign req_item.pos_x        = req_i.pos_x;
  assign req_item.pos_y        = req_i.pos_y;
  assign req_item.pos_z        = req_i.pos_z;
  assign req_item.corner_a     = req_i.corner_a;
  assign req_item.corner_b     = req_i.corner_b;
  assign req_item.corner_c     = req_i.corner_c;

  mvna_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mvna_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_i       (req_item),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_o       (rsp_item)
  );

  assign rsp_o.normal_index = rsp_item.normal_index;
  assign rsp_o.normal_x     = rsp_item.normal_x;
  assign rsp_o.normal_y     = rsp_item.normal_y;
  assign rsp_o.normal_z     = rsp_item.normal_z;
  assign rsp_o.zero_normal  = rsp_item.zero_normal;

`ifndef ASSERT_OFF
  a_no_accept_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> sts.clr_done)
    else $error("request accepted before the sum clear finished");

  a_result_from_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  a_zero_flag_vector : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.zero_normal |->
      rsp_o.normal_x == 16'sd0 && rsp_o.normal_y == 16'sd0 && rsp_o.normal_z == 16'sd0)
    else $error("zero normal flagged with nonzero components");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.normal_x <= 16'sd16384 && rsp_o.normal_x >= -16'sd16384 &&
      rsp_o.normal_y <= 16'sd16384 && rsp_o.normal_y >= -16'sd16384 &&
      rsp_o.normal_z <= 16'sd16384 && rsp_o.normal_z >= -16'sd16384)
    else $error("normal component outside unit range");
`endif

endmodule

// ===== hw/rtl/mvna_ctrl.sv =====
module mvna_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mvna_pkg::sts_t sts_i,
  output mvna_pkg::cmd_t cmd_o
);
  import mvna_pkg::*;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StDispatch,
    StTriRd,
    StTriMul,
    StTriSum,
    StRdSum,
    StRdMag,
    StNorm,
    StSq,
    StSqrt,
    StDiv,
    StResult
  } state_e;

  state_e     state_q;
  logic [4:0] cnt_q;
  logic [1:0] comp_q;

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= '0;
      comp_q  <= '0;
    end else begin
      unique case (state_q)
        StClear: begin
          if (sts_i.clr_done) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) state_q <= StDispatch;
        end
        StDispatch: begin
          cnt_q  <= '0;
          comp_q <= '0;
          priority if (sts_i.req_type == ReqTriangle && sts_i.tri_ok) state_q <= StTriRd;
          else if (sts_i.req_type == ReqRead) state_q <= StRdSum;
          else state_q <= StIdle;
        end
        StTriRd: begin
          if (cnt_q == 5'd3) begin
            cnt_q   <= '0;
            state_q <= StTriMul;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StTriMul: begin
          if (cnt_q == 5'd6) begin
            cnt_q   <= '0;
            state_q <= StTriSum;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StTriSum: begin
          if (cnt_q == 5'd5) begin
            cnt_q   <= '0;
            state_q <= StIdle;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StRdSum: state_q <= StRdMag;
        StRdMag: state_q <= StNorm;
        StNorm: begin
          cnt_q <= '0;
          priority if (sts_i.is_zero) state_q <= StResult;
          else if (sts_i.norm_done) state_q <= StSq;
        end
        StSq: begin
          if (cnt_q == 5'd3) begin
            cnt_q   <= '0;
            state_q <= StSqrt;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StSqrt: begin
          if (cnt_q == 5'd26) begin
            cnt_q   <= '0;
            state_q <= StDiv;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StDiv: begin
          if (cnt_q == 5'd16) begin
            cnt_q <= '0;
            if (comp_q == 2'd2) state_q <= StResult;
            else comp_q <= comp_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        StResult: begin
          if (sts_i.out_free) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = SelVertex;
    cmd_o.mul_sel  = MulUyWz;
    cmd_o.comp     = comp_q;
    unique case (state_q)
      StClear: cmd_o.clr_wr = !sts_i.clr_done;
      StIdle: cmd_o.load_req = in_valid_i;
      StDispatch: begin
        cmd_o.vert_wr = (sts_i.req_type == ReqWrite) && sts_i.vert_ok;
      end
      StTriRd: begin
        cmd_o.pos_rd   = (cnt_q != 5'd3);
        cmd_o.addr_sel = addr_sel_e'(cnt_q[1:0]);
        cmd_o.cap_p0   = (cnt_q == 5'd1);
        cmd_o.cap_pb   = (cnt_q == 5'd2);
        cmd_o.cap_pc   = (cnt_q == 5'd3);
      end
      StTriMul: begin
        cmd_o.mul_en  = (cnt_q != 5'd6);
        cmd_o.mul_sel = mul_sel_e'(cnt_q[3:0]);
      end
      StTriSum: begin
        cmd_o.sum_rd   = !cnt_q[0];
        cmd_o.sum_wr   = cnt_q[0];
        cmd_o.addr_sel = addr_sel_e'(cnt_q[2:1]);
      end
      StRdSum: cmd_o.sum_rd = 1'b1;
      StRdMag: cmd_o.load_mag = 1'b1;
      StNorm: cmd_o.norm_step = !sts_i.is_zero && !sts_i.norm_done;
      StSq: begin
        cmd_o.mul_en  = (cnt_q != 5'd3);
        cmd_o.mul_sel = mul_sel_e'(4'(MulSq0) + cnt_q[3:0]);
      end
      StSqrt: begin
        cmd_o.sqrt_init = (cnt_q == 5'd0);
        cmd_o.sqrt_step = (cnt_q != 5'd0);
      end
      StDiv: begin
        cmd_o.div_init  = (cnt_q == 5'd0);
        cmd_o.div_store = (cnt_q == 5'd16);
        cmd_o.div_step  = !cmd_o.div_init && !cmd_o.div_store;
      end
      StResult: cmd_o.out_load = sts_i.out_free;
      default: cmd_o.out_load = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/mvna_dpath.sv =====
module mvna_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mvna_pkg::cmd_t      cmd_i,
  output mvna_pkg::sts_t      sts_o,
  input  mvna_pkg::req_item_t req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mvna_pkg::rsp_item_t out_o
);
  import mvna_pkg::*;

  localparam int SqW = 52;
  localparam int LenW = 26;

  function automatic logic signed [SumW-1:0] sat_add(logic signed [SumW-1:0] s,
                                                     logic signed [CrossW-1:0] c);
    logic signed [SumW:0] r;
    r = {s[SumW-1], s} + {{(SumW + 1 - CrossW){c[CrossW-1]}}, c};
    if (r[SumW] != r[SumW-1]) begin
      return r[SumW] ? {1'b1, {(SumW - 1){1'b0}}} : {1'b0, {(SumW - 1){1'b1}}};
    end
    return r[SumW-1:0];
  endfunction

  function automatic logic signed [17:0] sx18(logic signed [PosW-1:0] v);
    return {{2{v[PosW-1]}}, v};
  endfunction

  req_item_t req_q;

  logic [3*PosW-1:0] pos_mem [NumVertices];
  logic [3*SumW-1:0] sum_mem [NumVertices];
  logic [3*PosW-1:0] pos_rd_q;
  logic [3*SumW-1:0] sum_rd_q;
  addr_t             sum_addr_q;
  addr_t             addr;
  logic [AddrW:0]    clr_cnt_q;

  logic signed [PosW-1:0]   p0_q [3];
  logic signed [17:0]       u_q [3];
  logic signed [17:0]       w_q [3];
  logic signed [24:0]       opa, opb;
  logic signed [49:0]       prod_q;
  mul_sel_e                 psel_q;
  logic                     pval_q;
  logic signed [CrossW-1:0] cross_q [3];
  logic [SqW-1:0]           q_q;

  logic [SumW-1:0] mag_q [3];
  logic            sign_q [3];
  logic [SumW-1:0] mag_or;

  logic [SqW-1:0]  sq_rem_q, sq_root_q, sq_bit_q, sq_trial;
  logic [LenW-1:0] len;
  logic [38:0]     num;
  logic [LenW-1:0] drem_q;
  logic [14:0]     dlow_q;
  logic [14:0]     quot_q;
  logic [LenW:0]   dtrial;
  logic [NormW-1:0] capped;

  logic signed [NormW-1:0] n_q [3];
  logic                    zero_q;
  logic                    out_valid_q;
  rsp_item_t               out_q;
  logic signed [PosW-1:0]  neg_z;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
  end

  always_comb begin
    unique case (cmd_i.addr_sel)
      SelA:      addr = to_addr(req_q.corner_a);
      SelB:      addr = to_addr(req_q.corner_b);
      SelC:      addr = to_addr(req_q.corner_c);
      SelVertex: addr = to_addr(req_q.vertex_index);
      default:   addr = to_addr(req_q.vertex_index);
    endcase
  end

  // Negating the most negative position would overflow, so it clamps.
  assign neg_z = (req_q.pos_z == {1'b1, {(PosW - 1){1'b0}}}) ? {1'b0, {(PosW - 1){1'b1}}}
                                                             : -req_q.pos_z;

  always_ff @(posedge clk_i) begin
    if (cmd_i.vert_wr) pos_mem[addr] <= {req_q.pos_y, neg_z, req_q.pos_x};
    if (cmd_i.pos_rd) pos_rd_q <= pos_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      sum_mem[clr_cnt_q[AddrW-1:0]] <= '0;
    end else if (cmd_i.vert_wr) begin
      sum_mem[addr] <= '0;
    end else if (cmd_i.sum_wr) begin
      sum_mem[sum_addr_q] <= {sat_add(sum_rd_q[2*SumW +: SumW], cross_q[2]),
                              sat_add(sum_rd_q[SumW +: SumW], cross_q[1]),
                              sat_add(sum_rd_q[0 +: SumW], cross_q[0])};
    end
    if (cmd_i.sum_rd) begin
      sum_rd_q   <= sum_mem[addr];
      sum_addr_q <= addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      pval_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
      pval_q <= cmd_i.mul_en;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Cross product terms and squared magnitudes share one multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul_sel)
      MulUyWz: begin opa = 25'(u_q[1]); opb = 25'(w_q[2]); end
      MulUzWy: begin opa = 25'(u_q[2]); opb = 25'(w_q[1]); end
      MulUzWx: begin opa = 25'(u_q[2]); opb = 25'(w_q[0]); end
      MulUxWz: begin opa = 25'(u_q[0]); opb = 25'(w_q[2]); end
      MulUxWy: begin opa = 25'(u_q[0]); opb = 25'(w_q[1]); end
      MulUyWx: begin opa = 25'(u_q[1]); opb = 25'(w_q[0]); end
      MulSq0:  begin opa = {1'b0, mag_q[0][23:0]}; opb = opa; end
      MulSq1:  begin opa = {1'b0, mag_q[1][23:0]}; opb = opa; end
      MulSq2:  begin opa = {1'b0, mag_q[2][23:0]}; opb = opa; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_p0) begin
      p0_q[0] <= pos_rd_q[0 +: PosW];
      p0_q[1] <= pos_rd_q[PosW +: PosW];
      p0_q[2] <= pos_rd_q[2*PosW +: PosW];
    end
    if (cmd_i.cap_pb) begin
      for (int i = 0; i < 3; i++) u_q[i] <= sx18(p0_q[i]) - sx18(pos_rd_q[i*PosW +: PosW]);
    end
    if (cmd_i.cap_pc) begin
      for (int i = 0; i < 3; i++) w_q[i] <= sx18(p0_q[i]) - sx18(pos_rd_q[i*PosW +: PosW]);
    end
    if (cmd_i.mul_en) begin
      prod_q <= opa * opb;
      psel_q <= cmd_i.mul_sel;
    end
    if (pval_q) begin
      unique case (psel_q)
        MulUyWz: cross_q[0] <= prod_q[CrossW-1:0];
        MulUzWy: cross_q[0] <= cross_q[0] - prod_q[CrossW-1:0];
        MulUzWx: cross_q[1] <= prod_q[CrossW-1:0];
        MulUxWz: cross_q[1] <= cross_q[1] - prod_q[CrossW-1:0];
        MulUxWy: cross_q[2] <= prod_q[CrossW-1:0];
        MulUyWx: cross_q[2] <= cross_q[2] - prod_q[CrossW-1:0];
        MulSq0:  q_q <= {2'b00, prod_q};
        MulSq1:  q_q <= q_q + {2'b00, prod_q};
        MulSq2:  q_q <= q_q + {2'b00, prod_q};
        default: q_q <= q_q;
      endcase
    end
  end

  assign mag_or = mag_q[0] | mag_q[1] | mag_q[2];

  // The largest magnitude is brought to [2^23, 2^24) one bit per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mag) begin
      for (int i = 0; i < 3; i++) begin
        sign_q[i] <= sum_rd_q[i*SumW + SumW - 1];
        if (!sts_o.vert_ok) mag_q[i] <= '0;
        else if (sum_rd_q[i*SumW + SumW - 1]) mag_q[i] <= ~sum_rd_q[i*SumW +: SumW] + 1'b1;
        else mag_q[i] <= sum_rd_q[i*SumW +: SumW];
        n_q[i] <= '0;
      end
    end else if (cmd_i.norm_step) begin
      for (int i = 0; i < 3; i++) begin
        if (|mag_or[SumW-1:24]) mag_q[i] <= mag_q[i] >> 1;
        else mag_q[i] <= mag_q[i] << 1;
      end
    end else if (cmd_i.div_store) begin
      n_q[cmd_i.comp] <= sign_q[cmd_i.comp] ? -capped : capped;
    end
  end

  assign sq_trial = sq_root_q + sq_bit_q;
  assign len      = sq_root_q[LenW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sq_rem_q  <= q_q;
      sq_root_q <= '0;
      sq_bit_q  <= SqW'(1) << 50;
    end else if (cmd_i.sqrt_step) begin
      if (sq_rem_q >= sq_trial) begin
        sq_rem_q  <= sq_rem_q - sq_trial;
        sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
      end else begin
        sq_root_q <= sq_root_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // The rounded numerator is below len * 2^15, so fifteen quotient bits suffice.
  assign num    = {1'b0, mag_q[cmd_i.comp][23:0], 14'd0} + 39'(len >> 1);
  assign dtrial = {drem_q, dlow_q[14]};
  assign capped = ({1'b0, quot_q} > NormW'(UnitOne)) ? NormW'(UnitOne) : {1'b0, quot_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      drem_q <= LenW'(num[38:15]);
      dlow_q <= num[14:0];
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      if (dtrial >= {1'b0, len}) begin
        drem_q <= LenW'(dtrial - {1'b0, len});
        quot_q <= {quot_q[13:0], 1'b1};
      end else begin
        drem_q <= dtrial[LenW-1:0];
        quot_q <= {quot_q[13:0], 1'b0};
      end
      dlow_q <= {dlow_q[13:0], 1'b0};
    end
  end

  assign zero_q = (mag_or == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.normal_index <= req_q.vertex_index;
      out_q.normal_x     <= n_q[0];
      out_q.normal_y     <= n_q[1];
      out_q.normal_z     <= n_q[2];
      out_q.zero_normal  <= zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    sts_o.clr_done  = (clr_cnt_q == (AddrW + 1)'(NumVertices));
    sts_o.req_type  = req_q.req_type;
    sts_o.vert_ok   = idx_in_range(req_q.vertex_index);
    sts_o.tri_ok    = idx_in_range(req_q.corner_a) && idx_in_range(req_q.corner_b) &&
                      idx_in_range(req_q.corner_c);
    sts_o.is_zero   = zero_q;
    sts_o.norm_done = !(|mag_or[SumW-1:24]) && mag_or[23];
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule
